>>> design/frd_pkg.sv
package frd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UC  = 8'h43;
  localparam logic [7:0] CH_UG  = 8'h47;
  localparam logic [7:0] CH_UN  = 8'h4E;
  localparam logic [7:0] CH_UT  = 8'h54;
  localparam logic [7:0] CH_UU  = 8'h55;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LU  = 8'h75;
  localparam logic [7:0] CH_LZ  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    KIND_HEAD       = 2'd0,
    KIND_BASE       = 2'd1,
    KIND_REC_END    = 2'd2,
    KIND_STREAM_END = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  out_byte;
    logic        record_status;
    logic [31:0] base_total;
  } out_beat_t;

  // Results produced by one accepted input beat, handed to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  first;
    out_beat_t  second;
  } push_t;

endpackage

>>> design/frd_parser.sv
module frd_parser #(
  parameter int COUNT_BITS = frd_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  frd_pkg::in_beat_t in_data,
  output frd_pkg::push_t    push
);

  typedef enum logic [1:0] {
    MODE_SEEK = 2'd0,
    MODE_HEAD = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic                  line_start_r, line_start_nxt;
  logic                  cr_pending_r, cr_pending_nxt;
  logic                  bad_r, bad_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [31:0]           total_clip;
  logic [COUNT_BITS:0]   count_sum;
  logic [1:0]            inc;
  logic                  restart;
  logic [1:0]            n_res;
  frd_pkg::out_beat_t    res0, res1;
  logic                  accept;

  assign accept = in_valid && in_ready;

  // Fit the counter to the 32-bit result field: saturate if wider, zero-extend if narrower.
  generate
    if (COUNT_BITS > 32) begin : g_clip_wide
      assign total_clip = (|count_r[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : count_r[31:0];
    end else if (COUNT_BITS == 32) begin : g_clip_eq
      assign total_clip = count_r;
    end else begin : g_clip_narrow
      assign total_clip = {{(32 - COUNT_BITS){1'b0}}, count_r};
    end
  endgenerate

  function automatic logic [7:0] norm_base(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b == frd_pkg::CH_LU || b == frd_pkg::CH_UU) begin
      c = frd_pkg::CH_UT;
    end else if (b >= frd_pkg::CH_LA && b <= frd_pkg::CH_LZ) begin
      c = b - frd_pkg::CASE_OFS;
    end
    return c;
  endfunction

  function automatic logic good_base(input logic [7:0] c);
    return (c == frd_pkg::CH_UA) || (c == frd_pkg::CH_UC) || (c == frd_pkg::CH_UG) ||
           (c == frd_pkg::CH_UT) || (c == frd_pkg::CH_UN);
  endfunction

  function automatic frd_pkg::out_beat_t mk(input frd_pkg::kind_t k, input logic [7:0] b,
                                            input logic s, input logic [31:0] t);
    frd_pkg::out_beat_t r;
    r.result_kind   = k;
    r.out_byte      = b;
    r.record_status = s;
    r.base_total    = t;
    return r;
  endfunction

  always_comb begin
    frd_pkg::out_beat_t rec_end;
    frd_pkg::out_beat_t item;
    logic [7:0]         b;
    logic [7:0]         c;
    logic               done;
    b              = in_data.text_byte;
    c              = norm_base(b);
    done           = 1'b0;
    rec_end        = mk(frd_pkg::KIND_REC_END, 8'h00,
                        bad_r || (count_r == '0), total_clip);
    item           = '0;
    mode_nxt       = mode_r;
    line_start_nxt = line_start_r;
    cr_pending_nxt = cr_pending_r;
    bad_nxt        = bad_r;
    restart        = 1'b0;
    inc            = 2'd0;
    n_res          = 2'd0;
    res0           = '0;
    res1           = '0;

    if (in_data.end_of_stream) begin
      // Close an open record, then mark end of stream; return to reset state.
      if (mode_r == MODE_HEAD || mode_r == MODE_SEQ) begin
        res0  = rec_end;
        res1  = mk(frd_pkg::KIND_STREAM_END, 8'h00, 1'b1, 32'h0);
        n_res = 2'd2;
      end else begin
        res0  = mk(frd_pkg::KIND_STREAM_END, 8'h00, 1'b1, 32'h0);
        n_res = 2'd1;
      end
      mode_nxt       = MODE_SEEK;
      line_start_nxt = 1'b1;
      cr_pending_nxt = 1'b0;
      bad_nxt        = 1'b0;
      restart        = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_HEAD: begin
          if (cr_pending_r) begin
            cr_pending_nxt = 1'b0;
            if (b == frd_pkg::CH_LF) begin
              mode_nxt       = MODE_SEQ;
              line_start_nxt = 1'b1;
              done           = 1'b1;
            end else begin
              res0  = mk(frd_pkg::KIND_HEAD, frd_pkg::CH_CR, 1'b0, 32'h0);
              n_res = 2'd1;
            end
          end
          if (!done) begin
            if (b == frd_pkg::CH_LF) begin
              mode_nxt       = MODE_SEQ;
              line_start_nxt = 1'b1;
            end else if (b == frd_pkg::CH_CR) begin
              cr_pending_nxt = 1'b1;
            end else begin
              item = mk(frd_pkg::KIND_HEAD, b, 1'b0, 32'h0);
              if (n_res == 2'd0) res0 = item;
              else res1 = item;
              n_res = n_res + 2'd1;
            end
          end
        end
        MODE_SEQ: begin
          if (cr_pending_r) begin
            cr_pending_nxt = 1'b0;
            if (b == frd_pkg::CH_LF) begin
              line_start_nxt = 1'b1;
              done           = 1'b1;
            end else begin
              // A stray CR becomes a counted, invalid base.
              res0    = mk(frd_pkg::KIND_BASE, frd_pkg::CH_CR, 1'b0, 32'h0);
              n_res   = 2'd1;
              inc     = 2'd1;
              bad_nxt = 1'b1;
            end
          end
          if (!done) begin
            if (line_start_r && b == frd_pkg::CH_GT) begin
              res0           = rec_end;
              n_res          = 2'd1;
              restart        = 1'b1;
              bad_nxt        = 1'b0;
              cr_pending_nxt = 1'b0;
              mode_nxt       = MODE_HEAD;
              line_start_nxt = 1'b0;
            end else if (line_start_r && b == frd_pkg::CH_LF) begin
              res0           = rec_end;
              n_res          = 2'd1;
              restart        = 1'b1;
              bad_nxt        = 1'b0;
              cr_pending_nxt = 1'b0;
              mode_nxt       = MODE_SEEK;
              line_start_nxt = 1'b1;
            end else if (b == frd_pkg::CH_LF) begin
              line_start_nxt = 1'b1;
            end else if (b == frd_pkg::CH_CR) begin
              cr_pending_nxt = 1'b1;
              line_start_nxt = 1'b0;
            end else begin
              item = mk(frd_pkg::KIND_BASE, c, 1'b0, 32'h0);
              if (n_res == 2'd0) res0 = item;
              else res1 = item;
              n_res = n_res + 2'd1;
              inc   = inc + 2'd1;
              if (!good_base(c)) bad_nxt = 1'b1;
              line_start_nxt = 1'b0;
            end
          end
        end
        default: begin
          if (line_start_r && b == frd_pkg::CH_GT) begin
            restart        = 1'b1;
            bad_nxt        = 1'b0;
            cr_pending_nxt = 1'b0;
            mode_nxt       = MODE_HEAD;
            line_start_nxt = 1'b0;
          end else begin
            mode_nxt       = MODE_SEEK;
            cr_pending_nxt = 1'b0;
            line_start_nxt = (b == frd_pkg::CH_LF);
          end
        end
      endcase
    end
  end

  // Saturating count: a carry out means the sum passed all ones.
  assign count_sum = {1'b0, count_r} + {{(COUNT_BITS - 1){1'b0}}, inc};
  assign count_nxt = restart ? '0 :
                     (count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SEEK;
      line_start_r <= 1'b1;
      cr_pending_r <= 1'b0;
      bad_r        <= 1'b0;
      count_r      <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      line_start_r <= line_start_nxt;
      cr_pending_r <= cr_pending_nxt;
      bad_r        <= bad_nxt;
      count_r      <= count_nxt;
    end
  end

  assign push.cnt    = accept ? n_res : 2'd0;
  assign push.first  = res0;
  assign push.second = res1;

endmodule

>>> design/frd_queue.sv
module frd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  frd_pkg::push_t     push,
  output logic               space_ok,
  output logic               q_valid,
  output frd_pkg::out_beat_t q_data,
  input  logic               pop
);

  localparam int DEPTH = frd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  frd_pkg::out_beat_t q_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]      wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Hold room for the largest burst one beat can push.
  assign space_ok = (cnt_r <= (AW + 1)'(DEPTH - 2));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + (AW + 1)'(push.cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) q_r[wr_ptr_p1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty result queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> space_ok)
    else $error("push without room");

endmodule

>>> design/frd_out_stage.sv
module frd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  frd_pkg::out_beat_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output frd_pkg::out_beat_t out_data
);

  logic               valid_r;
  frd_pkg::out_beat_t data_r;

  // Advance when the register is empty or its beat is being taken.
  assign pop = q_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= q_data;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> design/fasta_record_deframer_top.sv
// FASTA record deframer.
// Input channel (in_valid/in_ready/in_data): one beat per text byte, or one
// beat with end_of_stream set that carries no byte.
// Output channel (out_valid/out_ready/out_data): header bytes, normalized
// sequence bases, record-end beats with status and base count, and a final
// stream-end beat. One input beat yields zero, one or two output beats.
// Path: the parser writes an accepted beat's results into the queue as it
// accepts the beat, and the output register then loads them from the queue.
// Throughput: one input beat per cycle while each beat yields at most one
// result and the receiver keeps taking results; the single output register
// drains one result per cycle while out_ready is high, and the four-entry
// result queue between parser and output stage absorbs two-result beats.
// in_ready drops when the queue has fewer than two free entries.
// Reset (rst_n low, synchronous): parser returns to header search at line
// start, counters clear, queue and output register empty.
// Receiver stall: out_data holds until taken; the queue fills, then in_ready
// falls and the parser holds its state.
module fasta_record_deframer_top #(
  parameter int COUNT_BITS = frd_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output frd_pkg::out_beat_t out_data
);

  frd_pkg::push_t     push;
  logic               space_ok;
  logic               q_valid;
  frd_pkg::out_beat_t q_data;
  logic               pop;

  // Accept a beat only when the queue can take both of its possible results.
  assign in_ready = space_ok;

  // Front: classify bytes and build results.
  frd_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .push    (push)
  );

  // Decouple the two sides.
  frd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .space_ok(space_ok),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  // Back: registered output beat.
  frd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
